FILE: rtl/cwct_pkg.sv
`default_nettype none

package cwct_pkg;

  localparam int unsigned CntW = 32;
  localparam int unsigned WideW = 64;
  localparam int unsigned OpW = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 136;

  localparam logic [CntW-1:0] RstInitSend = 32'd0;
  localparam logic [CntW-1:0] RstSendMaxPkt = 32'd32768;
  localparam logic [CntW-1:0] RstInitRecv = 32'd0;
  localparam logic [CntW-1:0] RstRecvMaxPkt = 32'd32768;
  localparam logic [CntW-1:0] RstAdjThresh = 32'd65536;

  typedef enum logic [OpW-1:0] {
    OP_RESTART     = 3'd0,
    OP_SEND_COMMIT = 3'd1,
    OP_SEND_ADJUST = 3'd2,
    OP_RECV_COMMIT = 3'd3,
    OP_CONSUME     = 3'd4,
    OP_ADJ_COMMIT  = 3'd5,
    OP_GRANT       = 3'd6,
    OP_QUERY       = 3'd7
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_ARGUMENT = 3'd1,
    ST_SPACE    = 3'd2,
    ST_PROTOCOL = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_STATE    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_INIT_SEND    = 3'd0,
    REG_SEND_MAX_PKT = 3'd1,
    REG_INIT_RECV    = 3'd2,
    REG_RECV_MAX_PKT = 3'd3,
    REG_ADJ_THRESH   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CntW-1:0] init_send;
    logic [CntW-1:0] send_max_pkt;
    logic [CntW-1:0] init_recv;
    logic [CntW-1:0] recv_max_pkt;
    logic [CntW-1:0] adj_thresh;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0]  send_credit;
    logic [CntW-1:0]  recv_credit;
    logic [WideW-1:0] buffered;
    logic [WideW-1:0] pending;
  } state_t;

  typedef struct packed {
    status_t         status;
    logic [CntW-1:0] send_limit;
    logic            adjust_due;
    logic [CntW-1:0] adjust_limit;
    logic [CntW-1:0] send_window;
    logic [CntW-1:0] recv_window;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/cwct_cfg.sv
`default_nettype none

module cwct_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [cwct_pkg::CfgAddrW-1:0]    paddr,
  input  wire logic [cwct_pkg::CfgDataW-1:0]    pwdata,
  output logic      [cwct_pkg::CfgDataW-1:0]    prdata,
  output logic                                  pready,
  output cwct_pkg::cfg_t                        cfg
);

  cwct_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[cwct_pkg::CfgAddrW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_send    <= cwct_pkg::RstInitSend;
      cfg_r.send_max_pkt <= cwct_pkg::RstSendMaxPkt;
      cfg_r.init_recv    <= cwct_pkg::RstInitRecv;
      cfg_r.recv_max_pkt <= cwct_pkg::RstRecvMaxPkt;
      cfg_r.adj_thresh   <= cwct_pkg::RstAdjThresh;
    end else if (wr_en) begin
      unique case (cwct_pkg::reg_idx_t'(idx))
        cwct_pkg::REG_INIT_SEND:    cfg_r.init_send    <= pwdata;
        cwct_pkg::REG_SEND_MAX_PKT: cfg_r.send_max_pkt <= pwdata;
        cwct_pkg::REG_INIT_RECV:    cfg_r.init_recv    <= pwdata;
        cwct_pkg::REG_RECV_MAX_PKT: cfg_r.recv_max_pkt <= pwdata;
        cwct_pkg::REG_ADJ_THRESH:   cfg_r.adj_thresh   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cwct_pkg::reg_idx_t'(idx))
      cwct_pkg::REG_INIT_SEND:    prdata = cfg_r.init_send;
      cwct_pkg::REG_SEND_MAX_PKT: prdata = cfg_r.send_max_pkt;
      cwct_pkg::REG_INIT_RECV:    prdata = cfg_r.init_recv;
      cwct_pkg::REG_RECV_MAX_PKT: prdata = cfg_r.recv_max_pkt;
      cwct_pkg::REG_ADJ_THRESH:   prdata = cfg_r.adj_thresh;
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/cwct_core.sv
`default_nettype none

module cwct_core (
  input  wire cwct_pkg::cfg_t            cfg,
  input  wire cwct_pkg::state_t          st,
  input  wire logic [cwct_pkg::OpW-1:0]  op,
  input  wire logic [cwct_pkg::CntW-1:0] cnt,
  output cwct_pkg::state_t               st_nxt,
  output cwct_pkg::result_t              res
);

  localparam int unsigned W = cwct_pkg::CntW;
  localparam int unsigned WW = cwct_pkg::WideW;

  logic            cfg_ok;
  logic [W:0]      send_sum, send_diff, recv_sum, recv_diff;
  logic [WW:0]     buf_sum, buf_diff, pend_sum, pend_diff;
  logic [WW-1:0]   cnt64;
  logic [W-1:0]    room;
  cwct_pkg::status_t status;
  cwct_pkg::state_t  upd;

  assign cfg_ok = (cfg.send_max_pkt != '0) && (cfg.recv_max_pkt != '0) &&
                  (cfg.adj_thresh != '0);
  assign cnt64  = {{(WW-W){1'b0}}, cnt};

  // carry / borrow out of the top bit flags wrap
  assign send_sum  = {1'b0, st.send_credit} + {1'b0, cnt};
  assign send_diff = {1'b0, st.send_credit} - {1'b0, cnt};
  assign recv_sum  = {1'b0, st.recv_credit} + {1'b0, cnt};
  assign recv_diff = {1'b0, st.recv_credit} - {1'b0, cnt};
  assign buf_sum   = {1'b0, st.buffered} + {1'b0, cnt64};
  assign buf_diff  = {1'b0, st.buffered} - {1'b0, cnt64};
  assign pend_sum  = {1'b0, st.pending} + {1'b0, cnt64};
  assign pend_diff = {1'b0, st.pending} - {1'b0, cnt64};

  always_comb begin
    upd    = st;
    status = cwct_pkg::ST_OK;
    unique case (cwct_pkg::op_t'(op))
      cwct_pkg::OP_RESTART: begin
        upd.send_credit = cfg.init_send;
        upd.recv_credit = cfg.init_recv;
        upd.buffered    = '0;
        upd.pending     = '0;
      end
      cwct_pkg::OP_SEND_COMMIT: begin
        if (cnt > cfg.send_max_pkt) begin
          status = cwct_pkg::ST_ARGUMENT;
        end else if (send_diff[W]) begin
          status = cwct_pkg::ST_SPACE;
        end else begin
          upd.send_credit = send_diff[W-1:0];
        end
      end
      cwct_pkg::OP_SEND_ADJUST: begin
        if (send_sum[W]) begin
          status = cwct_pkg::ST_PROTOCOL;
        end else begin
          upd.send_credit = send_sum[W-1:0];
        end
      end
      cwct_pkg::OP_RECV_COMMIT: begin
        if (cnt > cfg.recv_max_pkt || recv_diff[W]) begin
          status = cwct_pkg::ST_PROTOCOL;
        end else if (buf_sum[WW]) begin
          status = cwct_pkg::ST_OVERFLOW;
        end else begin
          upd.recv_credit = recv_diff[W-1:0];
          upd.buffered    = buf_sum[WW-1:0];
        end
      end
      cwct_pkg::OP_CONSUME: begin
        if (buf_diff[WW]) begin
          status = cwct_pkg::ST_STATE;
        end else if (pend_sum[WW]) begin
          status = cwct_pkg::ST_OVERFLOW;
        end else begin
          upd.buffered = buf_diff[WW-1:0];
          upd.pending  = pend_sum[WW-1:0];
        end
      end
      cwct_pkg::OP_ADJ_COMMIT: begin
        if (pend_diff[WW] || recv_sum[W]) begin
          status = cwct_pkg::ST_STATE;
        end else begin
          upd.pending     = pend_diff[WW-1:0];
          upd.recv_credit = recv_sum[W-1:0];
        end
      end
      cwct_pkg::OP_GRANT: begin
        if (recv_sum[W]) begin
          status = cwct_pkg::ST_STATE;
        end else begin
          upd.recv_credit = recv_sum[W-1:0];
        end
      end
      cwct_pkg::OP_QUERY: ;
      default: ;
    endcase

    if (!cfg_ok) begin
      upd    = st;
      status = cwct_pkg::ST_ARGUMENT;
    end
  end

  assign st_nxt = upd;
  assign room   = ~upd.recv_credit;

  always_comb begin
    res.status      = status;
    res.send_window = upd.send_credit;
    res.recv_window = upd.recv_credit;
    if (cfg_ok) begin
      res.send_limit = (upd.send_credit < cfg.send_max_pkt) ? upd.send_credit
                                                            : cfg.send_max_pkt;
      res.adjust_due = (upd.pending >= {{(WW-W){1'b0}}, cfg.adj_thresh}) ||
                       ((upd.recv_credit == '0) && (upd.pending != '0));
      res.adjust_limit = (upd.pending < {{(WW-W){1'b0}}, room}) ?
                         upd.pending[W-1:0] : room;
    end else begin
      res.send_limit   = '0;
      res.adjust_due   = 1'b0;
      res.adjust_limit = '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/channel_window_credit_tracker_unit.sv
`default_nettype none

// channel   direction  payload
// in_       slave      tdata: operation, byte_count
// out_      master     tdata: status, send_limit, adjust_due, adjust_limit,
//                             send_window_now, receive_window_now
// cfg_      apb slave  five 32-bit registers at byte offsets 0x00..0x10
//
// one item per cycle while out_tready is high; out_tvalid rises as an accepted item
// moves from the input register through the update logic into the result register
// the window and count registers update as an item moves into the result register
// rst_n is synchronous, clears valids, windows and counts, loads config reset values
// a stall on out_tready holds the result and backs up into the input register

module channel_window_credit_tracker_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [2:0] operation, [34:3] byte_count, [39:35] zero
  input  wire logic [cwct_pkg::InDataW-1:0]      in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [2:0] status, [34:3] send_limit, [35] adjust_due, [67:36] adjust_limit,
  // [99:68] send_window_now, [131:100] receive_window_now, [135:132] zero
  output logic      [cwct_pkg::OutDataW-1:0]     out_tdata,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [cwct_pkg::CfgAddrW-1:0]     cfg_paddr,
  input  wire logic [cwct_pkg::CfgDataW-1:0]     cfg_pwdata,
  output logic      [cwct_pkg::CfgDataW-1:0]     cfg_prdata,
  output logic                                   cfg_pready
);

  cwct_pkg::cfg_t    cfg;
  cwct_pkg::state_t  state_r, state_nxt;
  cwct_pkg::result_t res_nxt, res_r;

  logic                       in_valid_r;
  logic [cwct_pkg::OpW-1:0]   in_op_r;
  logic [cwct_pkg::CntW-1:0]  in_cnt_r;
  logic                       out_valid_r;
  logic                       advance;
  logic                       proc;

  cwct_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  cwct_core u_core (
    .cfg    (cfg),
    .st     (state_r),
    .op     (in_op_r),
    .cnt    (in_cnt_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  assign advance   = !out_valid_r || out_tready;
  assign proc      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r  <= in_tdata[cwct_pkg::OpW-1:0];
      in_cnt_r <= in_tdata[cwct_pkg::OpW +: cwct_pkg::CntW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (proc) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, res_r.recv_window, res_r.send_window, res_r.adjust_limit,
                       res_r.adjust_due, res_r.send_limit, res_r.status};

`ifndef ASSERT_OFF
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !proc |=> $stable(state_r))
    else $error("window state changed with no item in process");

  a_fail_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    proc && (res_nxt.status != cwct_pkg::ST_OK) |=> state_r == $past(state_r))
    else $error("failed item updated the window state");

  a_limit_le_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.send_limit <= res_r.send_window)
    else $error("send limit exceeds send window");

  a_adj_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.adjust_limit <= ~res_r.recv_window)
    else $error("adjust limit would wrap the receive window");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> (res_r.send_window == state_r.send_credit) &&
             (res_r.recv_window == state_r.recv_credit))
    else $error("reported windows differ from stored windows");
`endif

endmodule

`default_nettype wire
